@@ rtl/core/ctcgd_pkg.sv @@
// Shared constants, register codes and types of the CTC greedy decoder.
`timescale 1ns / 1ps
package ctcgd_pkg;

    // Fixed field and register widths
    localparam int NUM_CLS_W   = 7;
    localparam int BLANK_W     = 6;
    localparam int SYM_W       = 6;
    localparam int SUM_BITS    = 26;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    // Defaults for the top-level parameters
    localparam int MAX_CLASSES_DEF = 64;
    localparam int SCORE_BITS_DEF  = 16;

    // Depth of the step queue between front and back
    localparam int STEP_Q_DEPTH = 2;

    // Register reset values
    localparam logic [NUM_CLS_W-1:0] NUM_CLASSES_RST = 7'd64;
    localparam logic [BLANK_W-1:0]   BLANK_CLS_RST   = 6'd63;
    localparam logic                 MERGE_RST       = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CLASSES = 2'd0,
        CFG_BLANK_CLS   = 2'd1,
        CFG_MERGE       = 2'd2
    } t_cfg_idx;

    // Configuration as seen by front and back
    typedef struct packed {
        logic [NUM_CLS_W-1:0] num_classes;
        logic [BLANK_W-1:0]   blank_cls;
        logic                 merge_repeated;
    } t_cfg;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/core/ctcgd_front.sv @@
// Front end: running argmax over the class scores of one time step.
`timescale 1ns / 1ps
module ctcgd_front
    import ctcgd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int SCORE_BITS  = SCORE_BITS_DEF,
    parameter int CW          = $clog2(MAX_CLASSES),
    parameter int QW          = 1 + CW + SCORE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_accept,
    input  logic signed [SCORE_BITS-1:0] i_class_score,
    input  logic                         i_sequence_end,
    output logic                         o_step_push,
    output logic [QW-1:0]                o_step_word
);

    localparam int CLS_NEED = $clog2(MAX_CLASSES + 1);
    localparam int NW       = (NUM_CLS_W > CLS_NEED) ? NUM_CLS_W : CLS_NEED;

    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                n_cnt;
    logic signed [SCORE_BITS-1:0] r_best_score;
    logic signed [SCORE_BITS-1:0] n_best_score;
    logic [CW-1:0]                r_best_class;
    logic [CW-1:0]                n_best_class;

    logic [NW-1:0] num_ext;
    logic [NW-1:0] eff_classes;
    logic [NW-1:0] last_idx;
    logic          take;
    logic          is_last;

    // Clamp the class count to the supported range
    always_comb begin
        num_ext = NW'(i_cfg.num_classes);
        if (num_ext < NW'(2)) begin
            eff_classes = NW'(2);
        end else if (num_ext > NW'(MAX_CLASSES)) begin
            eff_classes = NW'(MAX_CLASSES);
        end else begin
            eff_classes = num_ext;
        end
        last_idx = eff_classes - NW'(1);
    end

    // Track the maximum; the first index wins a tie
    always_comb begin
        take         = (r_cnt == '0) || (i_class_score > r_best_score);
        n_best_score = take ? i_class_score : r_best_score;
        n_best_class = take ? r_cnt : r_best_class;
        is_last      = NW'(r_cnt) >= last_idx;
        n_cnt        = is_last ? '0 : r_cnt + CW'(1);
    end

    // Hand a finished step to the queue
    assign o_step_push = i_accept && is_last;
    assign o_step_word = {i_sequence_end, n_best_class, n_best_score};

    // Advance the counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
    end

    // Hold the running best
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= '0;
            r_best_class <= '0;
        end else if (i_accept) begin
            r_best_score <= n_best_score;
            r_best_class <= n_best_class;
        end
    end

endmodule

@@ rtl/core/ctcgd_queue.sv @@
// Short queue of finished steps between front and back.
`timescale 1ns / 1ps
module ctcgd_queue
    import ctcgd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = STEP_Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_word,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_word,
    output t_q_stat          o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == NW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_word       = r_mem[r_rd_ptr];

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/core/ctcgd_back.sv @@
// Back end: blank and repeat filtering, sequence score and the result register.
`timescale 1ns / 1ps
module ctcgd_back
    import ctcgd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int SCORE_BITS  = SCORE_BITS_DEF,
    parameter int CW          = $clog2(MAX_CLASSES),
    parameter int QW          = 1 + CW + SCORE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  t_q_stat                    i_q_stat,
    input  logic [QW-1:0]              i_step_word,
    output logic                       o_step_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic                       o_symbol_valid,
    output logic [SYM_W-1:0]           o_symbol,
    output logic                       o_sequence_done,
    output logic signed [SUM_BITS-1:0] o_sequence_score
);

    localparam int AW   = ((SUM_BITS > SCORE_BITS) ? SUM_BITS : SCORE_BITS) + 2;
    localparam int MW   = (CW > BLANK_W) ? CW : BLANK_W;
    localparam logic signed [AW-1:0] SMAX = AW'((longint'(1) << (SUM_BITS - 1)) - 1);
    localparam logic signed [AW-1:0] SMIN = AW'(-(longint'(1) << (SUM_BITS - 1)));

    logic                         st_end;
    logic [CW-1:0]                st_class;
    logic signed [SCORE_BITS-1:0] st_score;

    logic signed [SUM_BITS-1:0] r_sum;
    logic                       r_prev_valid;
    logic [CW-1:0]              r_prev_class;
    logic                       r_out_valid;

    logic signed [AW-1:0]       diff;
    logic signed [SUM_BITS-1:0] sat;
    logic                       emit;

    assign {st_end, st_class, st_score} = i_step_word;

    // Take a step when the result register is free or being drained
    assign o_step_pop = !i_q_stat.empty && (!r_out_valid || i_pop);
    assign o_empty    = !r_out_valid;

    // Subtract the step maximum and clamp
    always_comb begin
        diff = AW'(r_sum) - AW'(st_score);
        if (diff > SMAX) begin
            sat = SUM_BITS'(SMAX);
        end else if (diff < SMIN) begin
            sat = SUM_BITS'(SMIN);
        end else begin
            sat = SUM_BITS'(diff);
        end
    end

    // Drop blanks and, in merge mode, repeats of the previous winner
    assign emit = (MW'(st_class) != MW'(i_cfg.blank_cls)) &&
                  !(i_cfg.merge_repeated && r_prev_valid && (st_class == r_prev_class));

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_step_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_step_pop) begin
            o_symbol_valid   <= emit;
            o_symbol         <= emit ? SYM_W'(st_class) : '0;
            o_sequence_done  <= st_end;
            o_sequence_score <= st_end ? sat : '0;
        end
    end

    // Sequence state: clear on sequence end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_prev_valid <= 1'b0;
            r_prev_class <= '0;
        end else if (o_step_pop) begin
            r_sum        <= st_end ? '0 : sat;
            r_prev_valid <= !st_end;
            r_prev_class <= st_end ? '0 : st_class;
        end
    end

endmodule

@@ rtl/core/ctc_greedy_decoder.sv @@
// CTC greedy decoder: one class score per cycle in while full is low, one result word per time step out.
// Throughput: one score word per cycle while full is low.
// The result of a step passes through the step queue and then the result register to the output.
// The two-entry step queue and the result register let input and output stall separately.
// Reset (synchronous, active low) restores register defaults and clears all step state.
`timescale 1ns / 1ps
module ctc_greedy_decoder
    import ctcgd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int SCORE_BITS  = SCORE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic signed [SCORE_BITS-1:0] i_class_score,
    input  logic                         i_sequence_end,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_symbol_valid,
    output logic [SYM_W-1:0]             o_symbol,
    output logic                         o_sequence_done,
    output logic signed [SUM_BITS-1:0]   o_sequence_score
);

    localparam int CW = $clog2(MAX_CLASSES);
    localparam int QW = 1 + CW + SCORE_BITS;

    t_cfg          r_cfg;
    t_q_stat       q_stat;
    logic          accept;
    logic          step_push;
    logic [QW-1:0] step_word_in;
    logic [QW-1:0] step_word_out;
    logic          step_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_classes    <= NUM_CLASSES_RST;
            r_cfg.blank_cls      <= BLANK_CLS_RST;
            r_cfg.merge_repeated <= MERGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_CLASSES: r_cfg.num_classes    <= i_cfg_data;
                CFG_BLANK_CLS:   r_cfg.blank_cls      <= i_cfg_data[BLANK_W-1:0];
                CFG_MERGE:       r_cfg.merge_repeated <= i_cfg_data[0];
                default:         r_cfg                <= r_cfg;
            endcase
        end
    end

    assign full   = q_stat.full;
    assign accept = push && !full;

    ctcgd_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .SCORE_BITS  (SCORE_BITS),
        .CW          (CW),
        .QW          (QW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_class_score  (i_class_score),
        .i_sequence_end (i_sequence_end),
        .o_step_push    (step_push),
        .o_step_word    (step_word_in)
    );

    ctcgd_queue #(
        .WIDTH (QW),
        .DEPTH (STEP_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step_push),
        .i_word  (step_word_in),
        .i_pop   (step_pop),
        .o_word  (step_word_out),
        .o_stat  (q_stat)
    );

    ctcgd_back #(
        .MAX_CLASSES (MAX_CLASSES),
        .SCORE_BITS  (SCORE_BITS),
        .CW          (CW),
        .QW          (QW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_stat         (q_stat),
        .i_step_word      (step_word_out),
        .o_step_pop       (step_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_symbol_valid   (o_symbol_valid),
        .o_symbol         (o_symbol),
        .o_sequence_done  (o_sequence_done),
        .o_sequence_score (o_sequence_score)
    );

    // A step never finishes while the queue is full
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !step_push)
        else $error("step finished while step queue full");

    // The score is reported only on a word that closes a sequence
    a_score_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_sequence_done) |-> (o_sequence_score == '0))
        else $error("sequence score set on a word that does not close a sequence");

    // No label is carried unless a symbol is emitted
    a_symbol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_symbol_valid) |-> (o_symbol == '0))
        else $error("symbol set without symbol_valid");

endmodule
